>>> sv/rmn_pkg.sv
// Shared types, register indexes and constants of the ring modulator oscillator.
package rmn_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int GAIN_W     = 33;
	localparam int MOD_W      = 17;
	localparam int MIX_W      = 17;
	localparam int SINE_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIX       = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 8'd3;

	localparam logic [31:0]      PHASE_INC_RST = 32'd42852281;
	localparam logic [MIX_W-1:0] MIX_ONE       = 17'd65536;
	localparam logic [31:0]      PHASE_HALF    = 32'h8000_0000;

	localparam logic signed [MOD_W-1:0] MOD_POS = 17'sh08000;
	localparam logic signed [MOD_W-1:0] MOD_NEG = 17'sh18000;
	localparam logic signed [MOD_W:0]   MOD_MID = 18'sd32768;

	localparam longint Q30_ONE = 64'sd1073741824;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SAW      = 2'd3
	} wave_t;

	typedef struct packed {
		logic [31:0]      phase_inc;
		wave_t            wave;
		logic [MIX_W-1:0] mix;
		logic             bypass;
	} cfg_t;

	// Quarter-wave sine entry from an odd degree-nine polynomial in Q30.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
		input int unsigned abits);
		longint x;
		longint x2;
		longint acc;
		longint y;
		longint s;
		x   = longint'(k) <<< (30 - abits);
		x2  = (x * x) / Q30_ONE;
		acc = 64'sd172272;
		acc = -64'sd5026995 + (acc * x2) / Q30_ONE;
		acc = 64'sd85569306 + (acc * x2) / Q30_ONE;
		acc = -64'sd693598668 + (acc * x2) / Q30_ONE;
		acc = 64'sd1686629713 + (acc * x2) / Q30_ONE;
		y   = (acc * x) / Q30_ONE;
		if (y < 0) begin
			y = 0;
		end
		s = (y + 64'sd16384) / 64'sd32768;
		if (s > 64'sd32768) begin
			s = 64'sd32768;
		end
		return s[SINE_W-1:0];
	endfunction

endpackage

>>> sv/rmn_if.sv
// Handshake interfaces for frames, results and configuration writes.
interface rmn_frame_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          phase_clear;

	modport source(output valid, output left_sample, output right_sample,
		output phase_clear, input ready);
	modport sink(input valid, input left_sample, input right_sample,
		input phase_clear, output ready);
endinterface

interface rmn_result_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_result;
	logic signed [SAMPLE_BITS-1:0] right_result;

	modport source(output valid, output left_result, output right_result, input ready);
	modport sink(input valid, input left_result, input right_result, output ready);
endinterface

interface rmn_cfg_if import rmn_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> sv/rmn_osc.sv
// Phase accumulator, waveform generator with sine ROM, and wet/dry gain stage.
module rmn_osc import rmn_pkg::*; #(
	parameter int SINE_ADDR_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     accept,
	input  logic                     clear,
	input  cfg_t                     cfg,
	output logic signed [GAIN_W-1:0] gain_s3
);

	localparam int QLEN = (1 << SINE_ADDR_BITS) + 1;
	localparam int AW   = SINE_ADDR_BITS + 1;

	function automatic logic [QLEN*SINE_W-1:0] build_rom();
		logic [QLEN*SINE_W-1:0] r;
		r = '0;
		for (int k = 0; k < QLEN; k++) begin
			r[k*SINE_W +: SINE_W] = sine_entry(k, SINE_ADDR_BITS);
		end
		return r;
	endfunction

	localparam logic [QLEN*SINE_W-1:0] SINE_ROM = build_rom();

	logic [31:0]               phase_q;
	logic [31:0]               base;
	logic [31:0]               p_s1;
	logic [SINE_ADDR_BITS-1:0] idx;
	logic [AW-1:0]             addr;
	logic [31:0]               tri_d;
	logic signed [MOD_W-1:0]   other_m;
	logic signed [MOD_W:0]     wide_m;
	logic [SINE_W-1:0]         rom_s2;
	logic                      neg_s2;
	logic signed [MOD_W-1:0]   other_s2;
	logic signed [MOD_W-1:0]   mod_val;
	logic signed [33:0]        wet;
	logic signed [33:0]        dry;
	logic signed [33:0]        gain_full;

	assign base = clear ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= cfg.bypass ? base : base + cfg.phase_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= base;
		end
	end

	always_comb begin
		idx   = p_s1[29 -: SINE_ADDR_BITS];
		addr  = p_s1[30] ? (AW'(QLEN - 1) - {1'b0, idx}) : {1'b0, idx};
		tri_d = p_s1[31] ? (p_s1 - PHASE_HALF) : (PHASE_HALF - p_s1);
		case (cfg.wave)
			WAVE_SQUARE: begin
				wide_m = p_s1[31] ? 18'(MOD_NEG) : 18'(MOD_POS);
			end
			WAVE_TRIANGLE: begin
				wide_m = $signed({1'b0, tri_d[31:15]}) - MOD_MID;
			end
			default: begin
				wide_m = $signed({2'b00, p_s1[31:16]}) - MOD_MID;
			end
		endcase
		other_m = wide_m[MOD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rom_s2   <= SINE_ROM[addr*SINE_W +: SINE_W];
			neg_s2   <= p_s1[31];
			other_s2 <= other_m;
		end
	end

	always_comb begin
		if (cfg.wave == WAVE_SINE) begin
			mod_val = neg_s2 ? -$signed({1'b0, rom_s2}) : $signed({1'b0, rom_s2});
		end else begin
			mod_val = other_s2;
		end
		wet       = 34'(mod_val) * $signed({17'd0, cfg.mix});
		dry       = $signed({2'b00, MIX_ONE - cfg.mix, 15'd0});
		gain_full = dry + wet;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gain_s3 <= gain_full[GAIN_W-1:0];
		end
	end

	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("Phase moved without a frame transaction.");

	a_phase_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cfg.bypass && !clear |=> $stable(phase_q))
		else $error("Phase advanced in bypass.");

	a_phase_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && clear && !cfg.bypass |=> phase_q == $past(cfg.phase_inc))
		else $error("Cleared phase did not restart from zero.");

endmodule

>>> sv/rmn_lane.sv
// One channel lane: split gain multiply, rounding, saturation and bypass select.
module rmn_lane import rmn_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [SAMPLE_BITS-1:0] sample_s3,
	input  logic                          bypass_s3,
	input  logic signed [GAIN_W-1:0]      gain_s3,
	output logic signed [SAMPLE_BITS-1:0] result_s5
);

	localparam int PW = SAMPLE_BITS + 17;
	localparam int TW = SAMPLE_BITS + 34;
	localparam logic signed [TW-1:0] ROUND = TW'(1) <<< 30;
	localparam logic signed [TW-1:0] MAXV  = (TW'(1) <<< (SAMPLE_BITS - 1)) - TW'(1);
	localparam logic signed [TW-1:0] MINV  = -(TW'(1) <<< (SAMPLE_BITS - 1));

	logic signed [PW-1:0]          pp_hi;
	logic signed [PW-1:0]          pp_lo;
	logic signed [PW-1:0]          pp_hi_s4;
	logic signed [PW-1:0]          pp_lo_s4;
	logic signed [SAMPLE_BITS-1:0] sample_s4;
	logic                          bypass_s4;
	logic signed [TW-1:0]          total;
	logic signed [TW-1:0]          quot;
	logic signed [SAMPLE_BITS-1:0] sat;

	always_comb begin
		pp_hi = PW'(sample_s3) * PW'($signed(gain_s3[GAIN_W-1:16]));
		pp_lo = PW'(sample_s3) * PW'($signed({1'b0, gain_s3[15:0]}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_hi_s4  <= pp_hi;
			pp_lo_s4  <= pp_lo;
			sample_s4 <= sample_s3;
			bypass_s4 <= bypass_s3;
		end
	end

	always_comb begin
		total = (TW'(pp_hi_s4) <<< 16) + TW'(pp_lo_s4) + ROUND;
		quot  = total >>> 31;
		if (quot > MAXV) begin
			sat = MAXV[SAMPLE_BITS-1:0];
		end else if (quot < MINV) begin
			sat = MINV[SAMPLE_BITS-1:0];
		end else begin
			sat = quot[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s5 <= bypass_s4 ? sample_s4 : sat;
		end
	end

endmodule

>>> sv/ring_modulator_nco.sv
// Top level of the stereo ring modulator with a phase-accumulator oscillator.
// An accepted frame moves through registers s1 to s5, and s5 presents its result.
// Throughput: one frame per cycle unless stalled; one 32-bit add closes the phase loop.
// Backpressure stalls the whole five-stage pipeline together while a result waits.
// Reset clears the phase to zero and loads the register defaults; the sine ROM is constant.
module ring_modulator_nco import rmn_pkg::*; #(
	parameter int CHANNELS       = 2,
	parameter int SAMPLE_BITS    = 24,
	parameter int SINE_ADDR_BITS = 10
) (
	input logic           clk,
	input logic           arst_n,
	rmn_frame_if.sink     frames,
	rmn_result_if.source  results,
	rmn_cfg_if.sink       cfg
);

	cfg_t                          cfg_q;
	logic                          adv;
	logic                          accept;
	logic                          vld_s1;
	logic                          vld_s2;
	logic                          vld_s3;
	logic                          vld_s4;
	logic                          vld_s5;
	logic                          bypass_s1;
	logic                          bypass_s2;
	logic                          bypass_s3;
	logic signed [GAIN_W-1:0]      gain_s3;
	logic signed [SAMPLE_BITS-1:0] smp_in [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] smp_s1 [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] smp_s2 [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] smp_s3 [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] res_s5 [CHANNELS];

	assign adv          = !vld_s5 || results.ready;
	assign accept       = frames.valid && adv;
	assign frames.ready = adv;
	assign cfg.ready    = 1'b1;
	assign results.valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_inc <= PHASE_INC_RST;
			cfg_q.wave      <= WAVE_SINE;
			cfg_q.mix       <= MIX_ONE;
			cfg_q.bypass    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PHASE_INC: cfg_q.phase_inc <= cfg.data;
				REG_WAVEFORM:  cfg_q.wave      <= wave_t'(cfg.data[1:0]);
				REG_MIX: begin
					cfg_q.mix <= (cfg.data[MIX_W-1:0] > MIX_ONE) ? MIX_ONE
						: cfg.data[MIX_W-1:0];
				end
				REG_BYPASS:    cfg_q.bypass    <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= frames.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign smp_in[0] = frames.left_sample;
	generate
		if (CHANNELS > 1) begin : g_right_in
			assign smp_in[1] = frames.right_sample;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			bypass_s1 <= cfg_q.bypass;
			bypass_s2 <= bypass_s1;
			bypass_s3 <= bypass_s2;
			smp_s1    <= smp_in;
			smp_s2    <= smp_s1;
			smp_s3    <= smp_s2;
		end
	end

	rmn_osc #(
		.SINE_ADDR_BITS(SINE_ADDR_BITS)
	) u_osc (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.accept  (accept),
		.clear   (frames.phase_clear),
		.cfg     (cfg_q),
		.gain_s3 (gain_s3)
	);

	generate
		for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
			rmn_lane #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_lane (
				.clk       (clk),
				.adv       (adv),
				.sample_s3 (smp_s3[c]),
				.bypass_s3 (bypass_s3),
				.gain_s3   (gain_s3),
				.result_s5 (res_s5[c])
			);
		end
	endgenerate

	assign results.left_result = res_s5[0];
	generate
		if (CHANNELS > 1) begin : g_right_out
			assign results.right_result = res_s5[1];
		end else begin : g_right_zero
			assign results.right_result = '0;
		end
	endgenerate

	a_mix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.mix <= MIX_ONE)
		else $error("Stored mix level exceeds one.");

	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s5) |-> $past(vld_s4))
		else $error("Result appeared without a frame in the last stage.");

	a_bypass_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.index == REG_BYPASS |=> cfg_q.bypass == $past(cfg.data[0]))
		else $error("Bypass register write was lost.");

endmodule
